### hw/rtl/fdl_pkg.sv
// Package for the feedback delay line: register map, field widths and
// fixed-point constants shared by the top level.
// No dependencies.
package fdl_pkg;

  localparam int DELAY_W  = 16;   // target delay, whole samples
  localparam int GAIN_W   = 16;   // feedback gain, Q0.16
  localparam int WET_W    = 17;   // wet share, Q0.16 with one included
  localparam int SMOOTH_W = 32;   // smoothed delay, Q16.16
  localparam int FRAC_W   = 16;   // fraction bits of gain, wet and delay
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 4;

  localparam logic [WET_W-1:0] WET_ONE = 17'h10000;

  typedef enum logic [1:0] {
    REG_TARGET_DELAY  = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1,
    REG_WET_AMOUNT    = 2'd2
  } reg_idx_e;

endpackage

### hw/rtl/fdl_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Standalone; no package dependencies.
module fdl_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/feedback_delay_line.sv
// Feedback delay line with wet/dry mix. The delay store is a single-port RAM that is read
// once and written once per sample, so the input stalls after each accepted request and
// requests are never accepted back to back. Each result passes through the pipeline and
// waits in an 8-entry output queue; beyond that spacing the input stalls only when 8
// requests are in flight or queued. The store needs no clearing pass after reset: the
// write pointer fills it in order, so an entry reads as zero until the pointer has
// passed it once.
// The delay length glides toward target_delay by 1/2^floor(log2(STORE_DEPTH)) of the gap
// per sample. Configure only while idle.
// Depends on fdl_pkg and fdl_ram.
module feedback_delay_line import fdl_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 65536,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready,
  // sample input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  // sample output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int K   = $clog2(STORE_DEPTH + 1) - 1;
  localparam int SW  = SAMPLE_BITS;
  localparam int EW  = SAMPLE_BITS + 20;
  localparam int CW  = (AW + 1 > DELAY_W + 1) ? AW + 1 : DELAY_W + 1;
  localparam int FD  = 8;
  localparam int FAW = $clog2(FD);

  localparam logic [AW:0]    DEPTH_W = STORE_DEPTH[AW:0];
  localparam logic [CW-1:0]  DEPTH_C = CW'(STORE_DEPTH);
  localparam logic [AW-1:0]  WP_LAST = AW'(STORE_DEPTH - 1);
  localparam logic [31:0]    RECIP   = 32'((64'd1 << 32) / 64'(STORE_DEPTH));
  localparam logic [FAW:0]   CRED_MAX = FD[FAW:0];

  localparam logic signed [EW-1:0] HI_E    = {{(EW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [EW-1:0] LO_E    = ~HI_E;
  localparam logic signed [EW-1:0] ROUND_E = EW'(32768);

  function automatic logic [SW-1:0] sat(input logic signed [EW-1:0] v);
    logic [SW-1:0] r;
    if (v > HI_E) begin
      r = HI_E[SW-1:0];
    end else if (v < LO_E) begin
      r = LO_E[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- configuration
  logic [DELAY_W-1:0] target_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [WET_W-1:0]   wet_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      gain_q   <= '0;
      wet_q    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TARGET_DELAY:  target_q <= pwdata[DELAY_W-1:0];
        REG_FEEDBACK_GAIN: gain_q   <= pwdata[GAIN_W-1:0];
        REG_WET_AMOUNT:    wet_q    <= pwdata[WET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TARGET_DELAY:  prdata = PDATA_W'(target_q);
      REG_FEEDBACK_GAIN: prdata = PDATA_W'(gain_q);
      REG_WET_AMOUNT:    prdata = PDATA_W'(wet_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- accept and smoothing
  logic                acc_q;
  logic [FAW:0]        credit_q, credit_d;
  logic                in_acc;
  logic [SMOOTH_W-1:0] smooth_q, smooth_next, tgt, diff, step;
  logic                up;
  logic [AW-1:0]       wp_q;
  logic                wrap_q;

  // stalling after each accepted request keeps the store port free for the write
  assign in_stall_o = acc_q | (credit_q == CRED_MAX);
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    tgt  = {target_q, {FRAC_W{1'b0}}};
    up   = tgt > smooth_q;
    diff = up ? tgt - smooth_q : smooth_q - tgt;
    step = diff >> K;
    if (step == '0) begin
      smooth_next = tgt;
    end else if (up) begin
      smooth_next = smooth_q + step;
    end else begin
      smooth_next = smooth_q - step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= 1'b0;
      smooth_q <= '0;
      wp_q     <= '0;
      wrap_q   <= 1'b0;
    end else begin
      acc_q <= in_acc;
      if (in_acc) begin
        smooth_q <= smooth_next;
        wp_q     <= (wp_q == WP_LAST) ? '0 : wp_q + 1'b1;
        if (wp_q == WP_LAST) begin
          wrap_q <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- address pipeline
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic signed [SW-1:0] x1_q, x2_q, x3_q, x4_q, x5_q, x6_q, x7_q;
  logic [DELAY_W-1:0]   d1_q, d2_q, d3_q;
  logic                 z1_q, z2_q, z3_q, z4_q, z5_q, z6_q;
  logic [AW-1:0]        wp1_q, wp2_q, wp3_q, wp4_q, wp5_q, wp6_q;
  logic                 wr1_q, wr2_q, wr3_q, wr4_q;
  logic [DELAY_W-1:0]   q2_q;
  logic [CW-1:0]        qd3_q;
  logic [AW-1:0]        r4_q, rd5_q;
  logic                 ok5_q, ok6_q;
  logic signed [SW-1:0] y7_q;
  logic signed [SW+17:0] pa8_q, pb8_q;

  logic [47:0]   recip_prod;
  logic [CW-1:0] qd_prod, r_raw, r_fix;
  logic          sub_ok;
  logic [AW:0]   rd_wrap;

  assign recip_prod = 48'(d1_q) * 48'(RECIP);
  assign qd_prod    = CW'(q2_q) * DEPTH_C;
  // reciprocal estimate is low by at most one, so one subtract corrects it
  assign r_raw      = CW'(d3_q) - qd3_q;
  assign r_fix      = (r_raw >= DEPTH_C) ? r_raw - DEPTH_C : r_raw;
  assign sub_ok     = wp4_q >= r4_q;
  assign rd_wrap    = {1'b0, wp4_q} + DEPTH_W - {1'b0, r4_q};

  // ---------------------------------------------------------------- store access
  logic [AW-1:0]        ram_addr;
  logic [SW-1:0]        ram_rdata;
  logic [SW-1:0]        fb_sample;
  logic signed [SW-1:0] y6;
  logic signed [SW+16:0] fb_prod;
  logic signed [EW-1:0] fb_rnd, fb_sum;

  assign ram_addr = v6_q ? wp6_q : rd5_q;

  fdl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (v5_q | v6_q),
    .we_i    (v6_q),
    .addr_i  (ram_addr),
    .wdata_i (fb_sample),
    .rdata_o (ram_rdata)
  );

  // zero delay passes the input; an entry not yet written reads as zero
  assign y6        = z6_q ? x6_q : (ok6_q ? $signed(ram_rdata) : '0);
  assign fb_prod   = $signed(y6) * $signed({1'b0, gain_q});
  assign fb_rnd    = EW'(fb_prod) + ROUND_E;
  assign fb_sum    = (fb_rnd >>> FRAC_W) + EW'(x6_q);
  assign fb_sample = sat(fb_sum);

  // ---------------------------------------------------------------- mix
  logic [WET_W-1:0]     wet_c, dry_c;
  logic signed [EW-1:0] mix_sum;
  logic [SW-1:0]        mix_sample;

  assign wet_c      = (wet_q > WET_ONE) ? WET_ONE : wet_q;
  assign dry_c      = WET_ONE - wet_c;
  assign mix_sum    = EW'(pa8_q) + EW'(pb8_q) + ROUND_E;
  assign mix_sample = sat(mix_sum >>> FRAC_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      v1_q <= in_acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q  <= sample_in_i;
    d1_q  <= smooth_next[SMOOTH_W-1:FRAC_W];
    z1_q  <= (smooth_next == '0);
    wp1_q <= wp_q;
    wr1_q <= wrap_q;

    x2_q  <= x1_q;
    d2_q  <= d1_q;
    z2_q  <= z1_q;
    wp2_q <= wp1_q;
    wr2_q <= wr1_q;
    q2_q  <= recip_prod[47:32];

    x3_q  <= x2_q;
    d3_q  <= d2_q;
    z3_q  <= z2_q;
    wp3_q <= wp2_q;
    wr3_q <= wr2_q;
    qd3_q <= qd_prod;

    x4_q  <= x3_q;
    z4_q  <= z3_q;
    wp4_q <= wp3_q;
    wr4_q <= wr3_q;
    r4_q  <= r_fix[AW-1:0];

    x5_q  <= x4_q;
    z5_q  <= z4_q;
    wp5_q <= wp4_q;
    rd5_q <= sub_ok ? wp4_q - r4_q : rd_wrap[AW-1:0];
    // valid once written: behind the pointer, or anywhere after the first wrap
    ok5_q <= wr4_q | (sub_ok & (r4_q != '0));

    x6_q  <= x5_q;
    z6_q  <= z5_q;
    wp6_q <= wp5_q;
    ok6_q <= ok5_q;

    x7_q  <= x6_q;
    y7_q  <= y6;

    pa8_q <= $signed(x7_q) * $signed({1'b0, dry_c});
    pb8_q <= $signed(y7_q) * $signed({1'b0, wet_c});
  end

  // ---------------------------------------------------------------- output queue
  logic [SW-1:0]  fifo_q [FD];
  logic [FAW-1:0] wptr_q, rptr_q;
  logic [FAW:0]   fill_q;
  logic           push, pop;

  assign push         = v8_q;
  assign out_valid_o  = (fill_q != '0);
  assign pop          = out_valid_o & ~out_stall_i;
  assign sample_out_o = fifo_q[rptr_q];

  always_comb begin
    case ({in_acc, pop})
      2'b10:   credit_d = credit_q + 1'b1;
      2'b01:   credit_d = credit_q - 1'b1;
      default: credit_d = credit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= mix_sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      wptr_q   <= '0;
      rptr_q   <= '0;
      fill_q   <= '0;
    end else begin
      credit_q <= credit_d;
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CRED_MAX)
    else $error("request credit count above queue depth");

  a_port_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(v5_q && v6_q))
    else $error("store read and write collide in one cycle");

  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_acc)
    else $error("requests accepted in consecutive cycles");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fill_q != CRED_MAX || pop))
    else $error("output queue overflow");

  a_fill_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= credit_q)
    else $error("queued results not covered by credits");

endmodule

### dv/feedback_delay_line_tb.sv
`timescale 1ns / 100ps
// Testbench for feedback_delay_line: drives samples and APB register writes, predicts
// every mixed output sample and checks it in order. Needs fdl_pkg and the block's RTL.
module feedback_delay_line_tb;
  import fdl_pkg::*;

  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned DEPTH_BITS  = $clog2(STORE_DEPTH);
  localparam int          GLIDE_SHIFT = $clog2(STORE_DEPTH);
  localparam longint      UNITY       = longint'(1) << FRAC_W;
  localparam longint      HALF        = UNITY / 2;
  localparam longint      SAMPLE_MAX  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint      SAMPLE_MIN  = -SAMPLE_MAX - 1;
  localparam logic [1:0]  REG_SPARE   = 2'd3;   // decoded by nobody
  localparam int          DRAIN_PAD   = 16;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          RANDOM_ITEMS = 500;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef enum int {RX_FREE, RX_COIN, RX_PATTERN, RX_CHOKE} rx_mode_e;

  class delay_line_scoreboard;
    bit signed [SAMPLE_BITS-1:0] echo_mem [STORE_DEPTH];
    bit [DEPTH_BITS-1:0] wr_ptr;
    bit [SMOOTH_W-1:0]   glide;
    bit [DELAY_W-1:0]    goal_delay;
    bit [GAIN_W-1:0]     fb_gain;
    bit [WET_W-1:0]      wet_share;
    sample_t             expected_out [$];
    int                  errors;

    function void flag(string what, logic signed [63:0] want, logic signed [63:0] got);
      errors++;
      if (errors <= 10)
        $display("%s mismatch: expected %0d, got %0d", what, want, got);
    endfunction

    function void set_reg(logic [1:0] idx, logic [PDATA_W-1:0] data);
      case (idx)
        REG_TARGET_DELAY:  goal_delay = data[DELAY_W-1:0];
        REG_FEEDBACK_GAIN: fb_gain = data[GAIN_W-1:0];
        REG_WET_AMOUNT:    wet_share = data[WET_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PDATA_W-1:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_TARGET_DELAY:  return PDATA_W'(goal_delay);
        REG_FEEDBACK_GAIN: return PDATA_W'(fb_gain);
        REG_WET_AMOUNT:    return PDATA_W'(wet_share);
        default:           return '0;
      endcase
    endfunction

    function sample_t clip(longint v);
      if (v > SAMPLE_MAX) return sample_t'(SAMPLE_MAX);
      if (v < SAMPLE_MIN) return sample_t'(SAMPLE_MIN);
      return sample_t'(v);
    endfunction

    // Glide the delay, read the echo, write back input plus feedback, blend.
    function sample_t mix_sample(sample_t x);
      bit [SMOOTH_W-1:0]   goal;
      bit [SMOOTH_W-1:0]   step;
      bit [DEPTH_BITS-1:0] rd;
      longint xn, yn, w, acc;
      goal = SMOOTH_W'(goal_delay) << FRAC_W;
      if (glide != goal) begin
        if (goal > glide) begin
          step = (goal - glide) >> GLIDE_SHIFT;
          glide = (step == 0) ? goal : glide + step;
        end else begin
          step = (glide - goal) >> GLIDE_SHIFT;
          glide = (step == 0) ? goal : glide - step;
        end
      end
      rd = wr_ptr - DEPTH_BITS'(glide >> FRAC_W);
      xn = longint'(x);
      yn = (glide == 0) ? xn : longint'(echo_mem[rd]);
      acc = (yn * longint'(fb_gain) + HALF) >>> FRAC_W;
      echo_mem[wr_ptr] = clip(xn + acc);
      w = (wet_share > WET_ONE) ? UNITY : longint'(wet_share);
      acc = (xn * (UNITY - w) + yn * w + HALF) >>> FRAC_W;
      wr_ptr = wr_ptr + 1'b1;
      return clip(acc);
    endfunction

    function void note_request(sample_t x);
      expected_out.push_back(mix_sample(x));
    endfunction

    function void check_result(sample_t y);
      sample_t want;
      if (expected_out.size() == 0) begin
        flag("unexpected sample_out", 'x, y);
      end else begin
        want = expected_out.pop_front();
        if (y !== want) flag("sample_out", want, y);
      end
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel, penable, pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]    pwdata;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_stall_o;
  sample_t               sample_in_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  sample_t               sample_out_o;

  delay_line_scoreboard  sb = new();
  int                    cycles;
  int                    burst_left;
  bit                    gaps_on;
  rx_mode_e              rx_mode;
  int                    rx_mode_left;

  feedback_delay_line #(
    .STORE_DEPTH(STORE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("feedback_delay_line_tb: done, errors");
      $finish;
    end
  end

  // Receiver: switch stall pattern every so often, free-running stretches included.
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(20, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_FREE:    out_stall_i <= 1'b0;
      RX_COIN:    out_stall_i <= ($urandom_range(0, 1) == 1);
      RX_PATTERN: out_stall_i <= ((cycles % 7) < 3);
      default:    out_stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Outputs are settled at the falling edge; the transfer completes at the next rise.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(sample_out_o);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic read_reg(input logic [1:0] idx);
    logic [PDATA_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PADDR_W'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    got = prdata;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== sb.reg_value(idx)) sb.flag("prdata", sb.reg_value(idx), got);
    @(posedge clk_i);
  endtask

  task automatic send_sample(input sample_t x);
    int  gap;
    bit  taken;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    sample_in_i <= x;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    sb.note_request(x);
  endtask

  // Drop valid and wait until every request has come back, then let the pipe empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'(SAMPLE_MAX);
      1:       return sample_t'(SAMPLE_MIN);
      2:       return sample_t'($urandom_range(0, 15)) - sample_t'(8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [PDATA_W-1:0] junk_high(int unsigned w, logic [PDATA_W-1:0] v);
    logic [PDATA_W-1:0] keep;
    keep = (PDATA_W'(1) << w) - 1;
    return ($urandom_range(0, 1) == 1) ? (($urandom & ~keep) | v) : v;
  endfunction

  initial begin
    logic [DELAY_W-1:0] tgt;
    logic [GAIN_W-1:0]  gain;
    logic [WET_W-1:0]   wet;
    int                 sent;
    int                 run;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    sample_in_i <= '0;
    out_stall_i <= 1'b0;
    rx_mode <= RX_FREE;
    rx_mode_left <= 0;
    cycles <= 0;
    burst_left = 0;
    gaps_on = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero delay passes the input straight through, fully dry.
    send_sample(sample_t'(0));
    send_sample(sample_t'(SAMPLE_MAX));
    send_sample(sample_t'(SAMPLE_MIN));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    drain();

    // Zero delay with full feedback and fully wet: the store write saturates.
    write_reg(REG_FEEDBACK_GAIN, 32'h0000_FFFF);
    write_reg(REG_WET_AMOUNT, 32'(WET_ONE));
    send_sample(sample_t'(SAMPLE_MAX));
    send_sample(sample_t'(SAMPLE_MIN));
    send_sample(sample_t'(1));
    send_sample(sample_t'(-1));
    drain();

    // One-sample delay holds from sample two on; wet above one clamps to fully wet.
    write_reg(REG_TARGET_DELAY, 32'h0000_0001);
    write_reg(REG_WET_AMOUNT, 32'h0001_FFFF);
    for (int i = 0; i < 8; i++)
      send_sample(sample_t'((i % 2) ? SAMPLE_MIN : SAMPLE_MAX));
    drain();

    // Half gain and half mix hit the round-half-up ties; the spare index is ignored.
    write_reg(REG_FEEDBACK_GAIN, 32'h0000_8000);
    write_reg(REG_WET_AMOUNT, 32'h0000_8000);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    read_reg(REG_TARGET_DELAY);
    read_reg(REG_FEEDBACK_GAIN);
    read_reg(REG_WET_AMOUNT);
    send_sample(sample_t'(1));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(3));
    send_sample(sample_t'(-3));
    send_sample(sample_t'(SAMPLE_MAX));
    send_sample(sample_t'(SAMPLE_MIN));
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       tgt = '0;
        1:       tgt = DELAY_W'(1);
        2:       tgt = '1;
        3:       tgt = DELAY_W'($urandom_range(2, 8));
        default: tgt = DELAY_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       gain = '0;
        1:       gain = '1;
        default: gain = GAIN_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       wet = '0;
        1:       wet = WET_ONE;
        2:       wet = WET_W'($urandom_range(65537, 131071));
        default: wet = WET_W'($urandom_range(0, 65536));
      endcase
      write_reg(REG_TARGET_DELAY, junk_high(DELAY_W, PDATA_W'(tgt)));
      write_reg(REG_FEEDBACK_GAIN, junk_high(GAIN_W, PDATA_W'(gain)));
      write_reg(REG_WET_AMOUNT, junk_high(WET_W, PDATA_W'(wet)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
      read_reg(REG_WET_AMOUNT);
      gaps_on = ($urandom_range(0, 3) != 0);
      run = $urandom_range(30, 90);
      for (int i = 0; i < run; i++)
        send_sample(pick_sample());
      sent += run;
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("feedback_delay_line_tb: done, clean");
    end else begin
      $display("feedback_delay_line_tb: done, errors");
    end
    $finish;
  end

endmodule

### feedback_delay_line.f
hw/rtl/fdl_pkg.sv
hw/rtl/fdl_ram.sv
hw/rtl/feedback_delay_line.sv
dv/feedback_delay_line_tb.sv
